/* rtl/core/blkofs_pkg.sv */
// Package for the blocked tensor offset pipeline.
// Holds the constants, register codes, stage types and the divider step function.
// No dependencies.
package blkofs_pkg;

	localparam int NUM_DIMS       = 4;
	localparam int COORD_W        = 31;
	localparam int SIZE_W         = 16;
	localparam int QUO_W          = 32;
	localparam int BITS_PER_STAGE = 4;
	localparam int DIV_STAGES     = QUO_W / BITS_PER_STAGE;
	localparam int CFG_W          = 38;
	localparam int REG_W          = 32;
	localparam int PROD_W         = COORD_W + REG_W;
	localparam int SUM_W          = PROD_W + 3;

	typedef enum logic [2:0] {
		REG_DIM_COUNT = 3'd0,
		REG_BASE      = 3'd1,
		REG_STRIDE_0  = 3'd2,
		REG_STRIDE_1  = 3'd3,
		REG_STRIDE_2  = 3'd4,
		REG_STRIDE_3  = 3'd5,
		REG_LAYOUT    = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic                              vld;
		logic [NUM_DIMS-1:0][COORD_W-1:0]  pos;
		logic [QUO_W-1:0]                  x;
		logic [SIZE_W-1:0]                 r;
		logic [SIZE_W-1:0]                 rem_a;
	} div_t;

	typedef struct packed {
		logic                              vld;
		logic [NUM_DIMS-1:0][PROD_W-1:0]   p;
		logic [SIZE_W-1:0]                 rem_a;
		logic [2*SIZE_W-1:0]               rb;
	} mul_t;

	typedef struct packed {
		logic              vld;
		logic [PROD_W:0]   sa;
		logic [PROD_W:0]   sb;
		logic [REG_W+1:0]  sc;
	} add_t;

	// Advance one stage of the restoring divider by BITS_PER_STAGE quotient bits.
	function automatic div_t div_step(div_t din, logic [SIZE_W-1:0] d);
		div_t           o;
		logic [SIZE_W:0] t;
		o = din;
		for (int k = 0; k < BITS_PER_STAGE; k++) begin
			t = {o.r, o.x[QUO_W-1]};
			o.x = {o.x[QUO_W-2:0], 1'b0};
			if (t >= {1'b0, d}) begin
				t = t - {1'b0, d};
				o.x[0] = 1'b1;
			end
			o.r = t[SIZE_W-1:0];
		end
		return o;
	endfunction

endpackage

/* rtl/core/blocked_tensor_offset.sv */
// Top level of the blocked tensor offset pipeline.
// Depends on blkofs_pkg for types, register codes and the divider step.
//
//  channel   signals                                   direction
//  input     in_valid, in_stall, coord_0..coord_3      word in
//  output    out_valid, out_stall, element_offset,     word out
//            overflow
//  config    cfg_we, cfg_idx, cfg_wdata                write only
//
// One word per cycle when not stalled. Stages: an entry register, two
// 8-stage divider pipelines (4 quotient bits per stage), a multiply stage and
// two adder stages, the last of which is the output register.
// Reset sets dim count to 4, clears other config and all stage valid bits.
// A stall on a valid output freezes all stages and is passed to in_stall.
module blocked_tensor_offset (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [2:0]                       cfg_idx,
	input  logic [blkofs_pkg::CFG_W-1:0]     cfg_wdata,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [blkofs_pkg::COORD_W-1:0]   coord_0,
	input  logic [blkofs_pkg::COORD_W-1:0]   coord_1,
	input  logic [blkofs_pkg::COORD_W-1:0]   coord_2,
	input  logic [blkofs_pkg::COORD_W-1:0]   coord_3,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [blkofs_pkg::PROD_W-1:0]    element_offset,
	output logic                             overflow
);
	import blkofs_pkg::*;

	logic [2:0]             dim_count_q;
	logic [REG_W-1:0]       base_q;
	logic [REG_W-1:0]       stride_q [NUM_DIMS];
	logic [CFG_W-1:0]       layout_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_count_q <= 3'd4;
			base_q      <= '0;
			for (int i = 0; i < NUM_DIMS; i++) stride_q[i] <= '0;
			layout_q    <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_idx))
				REG_DIM_COUNT: dim_count_q <= cfg_wdata[2:0];
				REG_BASE:      base_q      <= cfg_wdata[REG_W-1:0];
				REG_STRIDE_0:  stride_q[0] <= cfg_wdata[REG_W-1:0];
				REG_STRIDE_1:  stride_q[1] <= cfg_wdata[REG_W-1:0];
				REG_STRIDE_2:  stride_q[2] <= cfg_wdata[REG_W-1:0];
				REG_STRIDE_3:  stride_q[3] <= cfg_wdata[REG_W-1:0];
				REG_LAYOUT:    layout_q    <= cfg_wdata;
				default: ;
			endcase
		end
	end

	logic [2:0]        ndims;
	logic              act_a, act_b;
	logic [1:0]        dim_a, dim_b;
	logic [SIZE_W-1:0] size_a, size_b;

	always_comb begin
		ndims  = (dim_count_q > 3'(NUM_DIMS)) ? 3'(NUM_DIMS) : dim_count_q;
		act_a  = (layout_q[1:0] >= 2'd2);
		act_b  = (layout_q[1:0] >= 2'd1);
		dim_a  = act_a ? layout_q[21:20] : 2'd0;
		dim_b  = act_b ? layout_q[3:2] : 2'd0;
		size_a = (act_a && layout_q[37:22] != '0) ? layout_q[37:22] : SIZE_W'(1);
		size_b = (act_b && layout_q[19:4] != '0) ? layout_q[19:4] : SIZE_W'(1);
	end

	logic en;
	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	div_t in_s1;
	div_t in_d;
	logic [COORD_W-1:0] coords [NUM_DIMS];

	assign coords[0] = coord_0;
	assign coords[1] = coord_1;
	assign coords[2] = coord_2;
	assign coords[3] = coord_3;

	always_comb begin
		in_d     = '0;
		in_d.vld = in_valid;
		for (int i = 0; i < NUM_DIMS; i++)
			in_d.pos[i] = (3'(i) < ndims) ? coords[i] : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) in_s1 <= '0;
		else if (en) in_s1 <= in_d;
	end

	div_t da_in;
	div_t db_in;
	div_t da_s [1:DIV_STAGES];
	div_t db_s [1:DIV_STAGES];

	always_comb begin
		da_in   = in_s1;
		da_in.x = {1'b0, in_s1.pos[dim_a]};
		da_in.r = '0;
	end

	always_comb begin
		db_in            = da_s[DIV_STAGES];
		db_in.pos[dim_a] = da_s[DIV_STAGES].x[COORD_W-1:0];
		db_in.rem_a      = da_s[DIV_STAGES].r;
		db_in.x          = {1'b0, db_in.pos[dim_b]};
		db_in.r          = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= DIV_STAGES; k++) begin
				da_s[k] <= '0;
				db_s[k] <= '0;
			end
		end else if (en) begin
			da_s[1] <= div_step(da_in, size_a);
			db_s[1] <= div_step(db_in, size_b);
			for (int k = 1; k < DIV_STAGES; k++) begin
				da_s[k+1] <= div_step(da_s[k], size_a);
				db_s[k+1] <= div_step(db_s[k], size_b);
			end
		end
	end

	div_t dq;
	always_comb begin
		dq            = db_s[DIV_STAGES];
		dq.pos[dim_b] = db_s[DIV_STAGES].x[COORD_W-1:0];
	end

	mul_t mul_s2;
	add_t add_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_s2 <= '0;
		end else if (en) begin
			mul_s2.vld   <= dq.vld;
			for (int i = 0; i < NUM_DIMS; i++)
				mul_s2.p[i] <= {{REG_W{1'b0}}, dq.pos[i]} * {{COORD_W{1'b0}}, stride_q[i]};
			mul_s2.rem_a <= dq.rem_a;
			mul_s2.rb    <= {{SIZE_W{1'b0}}, dq.r} * {{SIZE_W{1'b0}}, size_a};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			add_s3 <= '0;
		end else if (en) begin
			add_s3.vld <= mul_s2.vld;
			add_s3.sa  <= {1'b0, mul_s2.p[0]} + {1'b0, mul_s2.p[1]};
			add_s3.sb  <= {1'b0, mul_s2.p[2]} + {1'b0, mul_s2.p[3]};
			add_s3.sc  <= {2'b0, base_q} + {2'b0, mul_s2.rb}
				+ {{(REG_W+2-SIZE_W){1'b0}}, mul_s2.rem_a};
		end
	end

	logic [SUM_W-1:0] sum;
	assign sum = {2'b0, add_s3.sa} + {2'b0, add_s3.sb}
		+ {{(SUM_W-REG_W-2){1'b0}}, add_s3.sc};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid      <= 1'b0;
			element_offset <= '0;
			overflow       <= 1'b0;
		end else if (en) begin
			out_valid      <= add_s3.vld;
			element_offset <= sum[PROD_W-1:0];
			overflow       <= (sum[SUM_W-1:PROD_W] != '0);
		end
	end

	a_entry: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_s1.vld)
		else $error("accepted word missing from entry stage");

	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(da_s[DIV_STAGES/2].vld) && $stable(mul_s2.vld))
		else $error("pipeline moved during output stall");

	a_rem: assert property (@(posedge clk) disable iff (!arst_n)
		da_s[DIV_STAGES].vld |-> da_s[DIV_STAGES].r < size_a)
		else $error("divider remainder not below block size");

endmodule

/* bench/blkofs_checker.sv */
// Checker for the blocked tensor offset block: watches both channels,
// predicts each offset from its own copy of the registers and compares.
// Depends on blkofs_pkg for register codes.
module blkofs_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_idx,
	input  logic [37:0] cfg_wdata,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [30:0] coord_0,
	input  logic [30:0] coord_1,
	input  logic [30:0] coord_2,
	input  logic [30:0] coord_3,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [62:0] element_offset,
	input  logic        overflow,
	output int          fail_count,
	output int          pending_count
);
	timeunit 1ns;
	timeprecision 1ps;
	import blkofs_pkg::*;

	typedef struct packed {
		logic [62:0] ofs;
		logic        ovf;
	} offset_word_t;

	logic [2:0]  dims_r;
	logic [31:0] base_r;
	logic [31:0] stride_r [4];
	logic [37:0] layout_r;
	offset_word_t offset_q [$];

	assign pending_count = offset_q.size();

	function automatic offset_word_t blocked_offset(logic [30:0] c0, logic [30:0] c1,
			logic [30:0] c2, logic [30:0] c3);
		logic [63:0]  pos [4];
		logic [127:0] acc;
		logic [63:0]  istride;
		logic [63:0]  bsize;
		logic [1:0]   bdim;
		int           nd;
		int           nb;
		offset_word_t r;
		nd = (dims_r > 4) ? 4 : int'(dims_r);
		nb = (layout_r[1:0] > 2) ? 2 : int'(layout_r[1:0]);
		pos[0] = (nd > 0) ? 64'(c0) : 64'd0;
		pos[1] = (nd > 1) ? 64'(c1) : 64'd0;
		pos[2] = (nd > 2) ? 64'(c2) : 64'd0;
		pos[3] = (nd > 3) ? 64'(c3) : 64'd0;
		acc = 128'(base_r);
		istride = 1;
		for (int b = nb - 1; b >= 0; b--) begin
			bdim = layout_r[b*18+2 +: 2];
			bsize = 64'(layout_r[b*18+4 +: 16]);
			if (bsize == 0)
				bsize = 1;
			acc += 128'(pos[bdim] % bsize) * 128'(istride);
			pos[bdim] = pos[bdim] / bsize;
			istride = istride * bsize;
		end
		for (int i = 0; i < nd; i++)
			acc += 128'(pos[i]) * 128'(stride_r[i]);
		r.ofs = acc[62:0];
		r.ovf = |acc[127:63];
		return r;
	endfunction

	task automatic report_mismatch(string what);
		$display("%0t mismatch: %s", $realtime, what);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		offset_word_t e;
		if (!arst_n) begin
			dims_r = 4;
			base_r = 0;
			stride_r = '{default: 0};
			layout_r = 0;
			offset_q.delete();
			fail_count = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (offset_q.size() == 0) begin
					report_mismatch("offset word with nothing expected");
				end else begin
					e = offset_q.pop_front();
					if (element_offset !== e.ofs)
						report_mismatch($sformatf("element_offset %0h want %0h",
							element_offset, e.ofs));
					if (overflow !== e.ovf)
						report_mismatch($sformatf("overflow %0b want %0b",
							overflow, e.ovf));
				end
			end
			if (in_valid && !in_stall)
				offset_q.insert(offset_q.size(),
					blocked_offset(coord_0, coord_1, coord_2, coord_3));
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_idx))
					REG_DIM_COUNT: dims_r = cfg_wdata[2:0];
					REG_BASE:      base_r = cfg_wdata[31:0];
					REG_STRIDE_0:  stride_r[0] = cfg_wdata[31:0];
					REG_STRIDE_1:  stride_r[1] = cfg_wdata[31:0];
					REG_STRIDE_2:  stride_r[2] = cfg_wdata[31:0];
					REG_STRIDE_3:  stride_r[3] = cfg_wdata[31:0];
					REG_LAYOUT:    layout_r = cfg_wdata;
					default: ;
				endcase
			end
		end
	end
endmodule

/* bench/tb_top.sv */
// Testbench top for blocked_tensor_offset: drives configuration phases,
// directed and random coordinate words, and gives the verdict.
// Depends on blkofs_pkg, the block and blkofs_checker.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import blkofs_pkg::*;

	localparam int LIMIT = 4000;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_idx;
	logic [37:0] cfg_wdata;
	logic        in_valid;
	logic        in_stall;
	logic [30:0] coord_0, coord_1, coord_2, coord_3;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [62:0] element_offset;
	logic        overflow;
	int          fail_count;
	int          pending_count;
	int          quiet_cycles = 0;
	bit          idle_on;

	blocked_tensor_offset i_dut (.*);

	blkofs_checker i_checker (.*);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	// watchdog: cycles with no accepted word
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > LIMIT) begin
			$display("tb_top NOT OK");
			$finish;
		end
	end

	always @(posedge clk)
		out_stall <= idle_on && ($urandom_range(99) < 24);

	function automatic logic [30:0] rand_coord();
		case ($urandom_range(5))
			0: return 0;
			1: return 31'h7fffffff;
			2: return 31'($urandom_range(15));
			3: return 31'($urandom_range(300));
			default: return 31'($urandom);
		endcase
	endfunction

	function automatic logic [31:0] rand_reg();
		case ($urandom_range(4))
			0: return 0;
			1: return 32'hffffffff;
			2: return $urandom_range(4096);
			default: return $urandom;
		endcase
	endfunction

	task automatic write_reg(cfg_reg_t r, logic [37:0] v);
		cfg_we <= 1;
		cfg_idx <= r;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 0;
	endtask

	task automatic send_coords(logic [30:0] a, logic [30:0] b, logic [30:0] c,
			logic [30:0] d);
		while (idle_on && $urandom_range(99) < 24) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		coord_0 <= a;
		coord_1 <= b;
		coord_2 <= c;
		coord_3 <= d;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 0;
		@(posedge clk);
		while (pending_count != 0)
			@(posedge clk);
		repeat (25) @(posedge clk);
	endtask

	function automatic logic [17:0] rand_block();
		logic [15:0] sz;
		case ($urandom_range(4))
			0: sz = 0;
			1: sz = 16'hffff;
			2: sz = 16'($urandom_range(1, 8));
			default: sz = 16'($urandom);
		endcase
		return {sz, 2'($urandom_range(3))};
	endfunction

	task automatic config_phase(int ph);
		logic [2:0] dc;
		dc = (ph % 3 == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(1, 4));
		write_reg(REG_DIM_COUNT, 38'(dc));
		write_reg(REG_BASE, 38'((ph == 1) ? 32'hffffffff : rand_reg()));
		write_reg(REG_STRIDE_0, 38'((ph == 1) ? 32'hffffffff : rand_reg()));
		write_reg(REG_STRIDE_1, 38'((ph == 1) ? 32'hffffffff : rand_reg()));
		write_reg(REG_STRIDE_2, 38'((ph == 1) ? 32'hffffffff : rand_reg()));
		write_reg(REG_STRIDE_3, 38'((ph == 1) ? 32'hffffffff : rand_reg()));
		write_reg(REG_LAYOUT, (ph == 1) ? 38'h3f_ffff_ffff
			: {rand_block(), rand_block(), 2'($urandom_range(3))});
	endtask

	initial begin
		arst_n = 0;
		cfg_we = 0;
		cfg_idx = 0;
		cfg_wdata = 0;
		in_valid = 0;
		coord_0 = 0;
		coord_1 = 0;
		coord_2 = 0;
		coord_3 = 0;
		idle_on = 1;
		repeat (7) @(posedge clk);
		arst_n = 1;
		@(posedge clk);

		// reset values, then extremes
		send_coords(31'h7fffffff, 31'h7fffffff, 31'h7fffffff, 31'h7fffffff);
		drain();
		write_reg(REG_DIM_COUNT, 4);
		write_reg(REG_BASE, 38'hffffffff);
		for (int i = 0; i < 4; i++)
			write_reg(cfg_reg_t'(REG_STRIDE_0 + i), 38'hffffffff);
		// two blocks of size 0xffff on dims 1 and 3
		write_reg(REG_LAYOUT, {16'hffff, 2'd3, 16'hffff, 2'd1, 2'd2});
		send_coords(0, 0, 0, 0);
		send_coords(31'h7fffffff, 31'h7fffffff, 31'h7fffffff, 31'h7fffffff);
		send_coords(31'h2aaaaaaa, 31'h55555555, 31'h2aaaaaaa, 31'h55555555);
		drain();
		// zero size, block count 3, block on unused dimension, zero dims
		write_reg(REG_LAYOUT, {16'd0, 2'd3, 16'd7, 2'd0, 2'd3});
		write_reg(REG_DIM_COUNT, 2);
		send_coords(31'd100, 31'd5, 31'd9, 31'd9);
		send_coords(31'h7fffffff, 0, 31'h7fffffff, 31'h7fffffff);
		drain();
		write_reg(REG_DIM_COUNT, 0);
		send_coords(31'd7, 31'd7, 31'd7, 31'd7);
		drain();
		write_reg(REG_DIM_COUNT, 7);
		send_coords(31'h7fffffff, 31'd1, 31'd2, 31'h7fffffff);
		drain();

		for (int ph = 0; ph < 12; ph++) begin
			config_phase(ph);
			idle_on = (ph != 5);
			for (int n = 0; n < 104; n++)
				send_coords(rand_coord(), rand_coord(), rand_coord(), rand_coord());
			drain();
		end
		idle_on = 0;
		repeat (25) @(posedge clk);
		if (fail_count == 0 && pending_count == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end
endmodule

/* filelist.f */
rtl/core/blkofs_pkg.sv
rtl/core/blocked_tensor_offset.sv
bench/blkofs_checker.sv
bench/tb_top.sv
